@@ sv/mdmc_pkg.sv @@
// Package for the MESI direct-mapped cache controller.
// Holds the field widths, MESI and bus codes, request/result structs and FSM states.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package mdmc_pkg;

    localparam int ADDR_W    = 20;
    localparam int WORD_W    = 32;
    localparam int TAG_W     = 12;
    localparam int CORE_W    = 2;
    localparam int COUNT_W   = 2;
    localparam int LINES_DEF = 64;
    localparam int WPL_DEF   = 4;

    localparam logic ACT_CORE  = 1'b0;
    localparam logic ACT_SNOOP = 1'b1;

    typedef enum logic [1:0] {
        MESI_I,
        MESI_S,
        MESI_E,
        MESI_M
    } mesi_t;

    typedef enum logic [1:0] {
        BUS_NONE,
        BUS_RD,
        BUS_RDX,
        BUS_FLUSH
    } bus_cmd_t;

    typedef enum logic [1:0] {
        REQ_RD,
        REQ_RDX,
        REQ_FLUSH
    } req_cmd_t;

    typedef enum logic [1:0] {
        KIND_REPLY,
        KIND_REQUEST,
        KIND_DATA
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RD_WORD,
        ST_PUT_WORD,
        ST_PUT_REQ,
        ST_PUT_REPLY
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        mesi_t            mesi;
    } meta_t;

    typedef struct packed {
        logic               action;
        logic               is_write;
        logic [ADDR_W-1:0]  address;
        logic [WORD_W-1:0]  store_word;
        bus_cmd_t           bus_command;
        logic [CORE_W-1:0]  bus_origin;
        logic [WORD_W-1:0]  bus_word;
        logic [CORE_W-1:0]  served_core;
        logic [COUNT_W-1:0] flush_word_count;
        logic               shared_seen;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic              hit;
        logic              stall_res;
        logic [WORD_W-1:0] load_word;
        req_cmd_t          request_command;
        logic [ADDR_W-1:0] request_address;
        logic [WORD_W-1:0] flush_data;
        logic              assert_shared;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

@@ sv/mdmc_if.sv @@
// Valid/ready channel interfaces for the cache controller's request and result streams.
// Depends on mdmc_pkg for the payload structs.
`default_nettype none

interface mdmc_item_if;
    logic           valid;
    logic           ready;
    mdmc_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mdmc_result_if;
    logic             valid;
    logic             ready;
    mdmc_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/mesi_direct_mapped_cache_ctrl_top.sv @@
// Top level of the MESI snooping direct-mapped write-back cache controller.
// Depends on mdmc_pkg, mdmc_if, mdmc_ram and mdmc_ctrl.
//
// After reset the block sweeps both memories to zero, one data word per cycle, and accepts no
// request until the sweep is done; own_core may be written during that time. Each request is
// then taken one at a time: on accept the tag/state memory and the data word are read, the
// lookup state decides and writes back, and each result is then loaded while the result
// register is free. A line flush reads the data word memory through its single read port,
// alternating a word read with putting out that word. A finished result waits in the output
// register while the next request is accepted.
`default_nettype none

module mesi_direct_mapped_cache_ctrl_top #(
    parameter int LINES          = mdmc_pkg::LINES_DEF,
    parameter int WORDS_PER_LINE = mdmc_pkg::WPL_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [mdmc_pkg::CORE_W-1:0] cfg_wdata,
    mdmc_item_if.sink                        item,
    mdmc_result_if.source                    result
);

    localparam int WDEPTH = LINES * WORDS_PER_LINE;

    logic                              meta_we;
    logic [$clog2(LINES)-1:0]          meta_waddr;
    mdmc_pkg::meta_t                   meta_wdata;
    logic                              meta_re;
    logic [$clog2(LINES)-1:0]          meta_raddr;
    mdmc_pkg::meta_t                   meta_rdata;
    logic                              word_we;
    logic [$clog2(WDEPTH)-1:0]         word_waddr;
    logic [mdmc_pkg::WORD_W-1:0]       word_wdata;
    logic                              word_re;
    logic [$clog2(WDEPTH)-1:0]         word_raddr;
    logic [mdmc_pkg::WORD_W-1:0]       word_rdata;

    mdmc_ram #(
        .DEPTH (LINES),
        .WIDTH ($bits(mdmc_pkg::meta_t))
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    mdmc_ram #(
        .DEPTH (WDEPTH),
        .WIDTH (mdmc_pkg::WORD_W)
    ) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .re    (word_re),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    mdmc_ctrl #(
        .LINES          (LINES),
        .WORDS_PER_LINE (WORDS_PER_LINE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item       (item),
        .result     (result),
        .meta_we    (meta_we),
        .meta_waddr (meta_waddr),
        .meta_wdata (meta_wdata),
        .meta_re    (meta_re),
        .meta_raddr (meta_raddr),
        .meta_rdata (meta_rdata),
        .word_we    (word_we),
        .word_waddr (word_waddr),
        .word_wdata (word_wdata),
        .word_re    (word_re),
        .word_raddr (word_raddr),
        .word_rdata (word_rdata)
    );

endmodule

`default_nettype wire

@@ sv/mdmc_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on mdmc_pkg for default sizes only.
`default_nettype none

module mdmc_ram #(
    parameter int DEPTH = mdmc_pkg::LINES_DEF,
    parameter int WIDTH = mdmc_pkg::WORD_W
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/mdmc_ctrl.sv @@
// Cache controller sequencer: lookup, MESI update, eviction and snoop flushes, result register.
// Depends on mdmc_pkg and mdmc_if; drives the tag/state RAM and the data word RAM.
`default_nettype none

module mdmc_ctrl #(
    parameter int LINES          = mdmc_pkg::LINES_DEF,
    parameter int WORDS_PER_LINE = mdmc_pkg::WPL_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cfg_we,
    input  wire logic [mdmc_pkg::CORE_W-1:0]               cfg_wdata,
    mdmc_item_if.sink                                      item,
    mdmc_result_if.source                                  result,
    output logic                                           meta_we,
    output logic [$clog2(LINES)-1:0]                       meta_waddr,
    output mdmc_pkg::meta_t                                meta_wdata,
    output logic                                           meta_re,
    output logic [$clog2(LINES)-1:0]                       meta_raddr,
    input  wire mdmc_pkg::meta_t                           meta_rdata,
    output logic                                           word_we,
    output logic [$clog2(LINES*WORDS_PER_LINE)-1:0]        word_waddr,
    output logic [mdmc_pkg::WORD_W-1:0]                    word_wdata,
    output logic                                           word_re,
    output logic [$clog2(LINES*WORDS_PER_LINE)-1:0]        word_raddr,
    input  wire logic [mdmc_pkg::WORD_W-1:0]               word_rdata
);

    localparam int LOG_WPL   = $clog2(WORDS_PER_LINE);
    localparam int LOG_LINES = $clog2(LINES);
    localparam int OFF_W     = (LOG_WPL > 0) ? LOG_WPL : 1;
    localparam int WADDR_W   = LOG_WPL + LOG_LINES;
    localparam logic [OFF_W-1:0] LAST_WORD = OFF_W'(WORDS_PER_LINE - 1);

    mdmc_pkg::state_t                 state_reg, state_next;
    mdmc_pkg::item_t                  item_reg;
    logic [mdmc_pkg::CORE_W-1:0]      own_core_reg;
    logic                             miss_pending_reg, miss_pending_next;
    logic [WADDR_W-1:0]               clr_reg;
    logic [OFF_W-1:0]                 w_reg;
    logic [mdmc_pkg::ADDR_W-1:0]      flush_addr_reg;
    logic                             shared_reg;
    logic                             reply_hit_reg;
    logic                             reply_stall_reg;
    logic [mdmc_pkg::WORD_W-1:0]      reply_load_reg;
    mdmc_pkg::result_t                out_reg, out_next;
    logic                             out_valid_reg;

    logic                             accept;
    logic                             slot_free;
    logic                             push;
    logic [LOG_LINES-1:0]             idx_cur;
    logic [mdmc_pkg::TAG_W-1:0]       tag_cur;
    logic                             is_core;
    mdmc_pkg::mesi_t                  need;
    logic                             match;
    logic                             core_hit;
    logic                             evict;
    logic                             snoop_hit;
    logic                             fill_own;
    logic                             fill_word;
    logic [mdmc_pkg::ADDR_W-1:0]      victim_addr;

    assign idx_cur = item_reg.address[LOG_WPL +: LOG_LINES];
    assign tag_cur = mdmc_pkg::TAG_W'(item_reg.address >> WADDR_W);
    assign is_core = (item_reg.action == mdmc_pkg::ACT_CORE);

    always_comb
    begin : decide
        need        = item_reg.is_write ? mdmc_pkg::MESI_E : mdmc_pkg::MESI_S;
        match       = (meta_rdata.tag == tag_cur);
        core_hit    = match && (meta_rdata.mesi >= need);
        evict       = !match && (meta_rdata.mesi == mdmc_pkg::MESI_M);
        snoop_hit   = ((item_reg.bus_command == mdmc_pkg::BUS_RD)
                       || (item_reg.bus_command == mdmc_pkg::BUS_RDX))
                      && (item_reg.bus_origin != own_core_reg)
                      && match && (meta_rdata.mesi != mdmc_pkg::MESI_I);
        fill_own    = (item_reg.bus_command == mdmc_pkg::BUS_FLUSH)
                      && (own_core_reg == item_reg.bus_origin)
                      && (own_core_reg == item_reg.served_core)
                      && (item_reg.flush_word_count == '0);
        fill_word   = (item_reg.bus_command == mdmc_pkg::BUS_FLUSH)
                      && (own_core_reg != item_reg.bus_origin)
                      && (own_core_reg == item_reg.served_core);
        victim_addr = mdmc_pkg::ADDR_W'((32'(meta_rdata.tag) << WADDR_W)
                                        | 32'(item_reg.address[WADDR_W-1:0]));
    end

    always_comb
    begin : next_state
        state_next = state_reg;
        unique case (state_reg)
            mdmc_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = mdmc_pkg::ST_IDLE;
                end
            end
            mdmc_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = mdmc_pkg::ST_LOOKUP;
                end
            end
            mdmc_pkg::ST_LOOKUP:
            begin
                if (is_core)
                begin
                    if (core_hit || miss_pending_reg)
                    begin
                        state_next = mdmc_pkg::ST_PUT_REPLY;
                    end
                    else if (evict)
                    begin
                        state_next = mdmc_pkg::ST_RD_WORD;
                    end
                    else
                    begin
                        state_next = mdmc_pkg::ST_PUT_REQ;
                    end
                end
                else if (snoop_hit)
                begin
                    state_next = (meta_rdata.mesi == mdmc_pkg::MESI_M)
                                 ? mdmc_pkg::ST_RD_WORD : mdmc_pkg::ST_PUT_REPLY;
                end
                else
                begin
                    state_next = mdmc_pkg::ST_IDLE;
                end
            end
            mdmc_pkg::ST_RD_WORD:
            begin
                state_next = mdmc_pkg::ST_PUT_WORD;
            end
            mdmc_pkg::ST_PUT_WORD:
            begin
                if (slot_free)
                begin
                    if (w_reg != LAST_WORD)
                    begin
                        state_next = mdmc_pkg::ST_RD_WORD;
                    end
                    else if (is_core)
                    begin
                        state_next = mdmc_pkg::ST_PUT_REQ;
                    end
                    else
                    begin
                        state_next = mdmc_pkg::ST_PUT_REPLY;
                    end
                end
            end
            mdmc_pkg::ST_PUT_REQ:
            begin
                if (slot_free)
                begin
                    state_next = mdmc_pkg::ST_PUT_REPLY;
                end
            end
            mdmc_pkg::ST_PUT_REPLY:
            begin
                if (slot_free)
                begin
                    state_next = mdmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mdmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin : outputs
        item.ready        = (state_reg == mdmc_pkg::ST_IDLE);
        accept            = item.valid && item.ready;
        slot_free         = !out_valid_reg || result.ready;
        result.valid      = out_valid_reg;
        result.payload    = out_reg;

        meta_re           = accept;
        meta_raddr        = item.payload.address[LOG_WPL +: LOG_LINES];
        word_re           = accept || (state_reg == mdmc_pkg::ST_RD_WORD);
        word_raddr        = accept ? item.payload.address[WADDR_W-1:0]
                                   : ((WADDR_W'(idx_cur) << LOG_WPL) | WADDR_W'(w_reg));

        meta_we           = 1'b0;
        meta_waddr        = idx_cur;
        meta_wdata        = '{tag: meta_rdata.tag, mesi: meta_rdata.mesi};
        word_we           = 1'b0;
        word_waddr        = item_reg.address[WADDR_W-1:0];
        word_wdata        = item_reg.store_word;
        miss_pending_next = miss_pending_reg;
        push              = 1'b0;
        out_next          = '0;

        unique case (state_reg)
            mdmc_pkg::ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = LOG_LINES'(clr_reg >> LOG_WPL);
                meta_wdata = '{tag: '0, mesi: mdmc_pkg::MESI_I};
                word_we    = 1'b1;
                word_waddr = clr_reg;
                word_wdata = '0;
            end
            mdmc_pkg::ST_LOOKUP:
            begin
                if (is_core)
                begin
                    if (core_hit)
                    begin
                        miss_pending_next = 1'b0;
                        if (item_reg.is_write)
                        begin
                            word_we         = 1'b1;
                            meta_we         = 1'b1;
                            meta_wdata.mesi = mdmc_pkg::MESI_M;
                        end
                    end
                    else
                    begin
                        miss_pending_next = 1'b1;
                    end
                end
                else if (snoop_hit)
                begin
                    meta_we         = 1'b1;
                    meta_wdata.mesi = (item_reg.bus_command == mdmc_pkg::BUS_RD)
                                      ? mdmc_pkg::MESI_S : mdmc_pkg::MESI_I;
                end
                else if (fill_own)
                begin
                    meta_we         = 1'b1;
                    meta_wdata.mesi = mdmc_pkg::MESI_E;
                end
                else if (fill_word)
                begin
                    word_we    = 1'b1;
                    word_wdata = item_reg.bus_word;
                    if (item_reg.flush_word_count == '0)
                    begin
                        meta_we    = 1'b1;
                        meta_wdata = '{tag: tag_cur,
                                       mesi: item_reg.shared_seen ? mdmc_pkg::MESI_S
                                                                  : mdmc_pkg::MESI_E};
                    end
                end
            end
            mdmc_pkg::ST_PUT_WORD:
            begin
                push                     = slot_free;
                out_next.kind            = mdmc_pkg::KIND_DATA;
                out_next.request_command = mdmc_pkg::REQ_FLUSH;
                out_next.request_address = flush_addr_reg;
                out_next.flush_data      = word_rdata;
                out_next.assert_shared   = shared_reg;
            end
            mdmc_pkg::ST_PUT_REQ:
            begin
                push                     = slot_free;
                out_next.kind            = mdmc_pkg::KIND_REQUEST;
                out_next.request_command = item_reg.is_write ? mdmc_pkg::REQ_RDX
                                                             : mdmc_pkg::REQ_RD;
                out_next.request_address = item_reg.address;
            end
            mdmc_pkg::ST_PUT_REPLY:
            begin
                push                   = slot_free;
                out_next.kind          = mdmc_pkg::KIND_REPLY;
                out_next.hit           = reply_hit_reg;
                out_next.stall_res     = reply_stall_reg;
                out_next.load_word     = reply_load_reg;
                out_next.assert_shared = shared_reg;
                out_next.last          = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mdmc_pkg::ST_CLEAR;
            own_core_reg     <= '0;
            miss_pending_reg <= 1'b0;
            clr_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            miss_pending_reg <= miss_pending_next;
            if (cfg_we)
            begin
                own_core_reg <= cfg_wdata;
            end
            if (state_reg == mdmc_pkg::ST_CLEAR)
            begin
                clr_reg <= WADDR_W'(clr_reg + 1'b1);
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item.payload;
        end
        if (push)
        begin
            out_reg <= out_next;
        end
        if (state_reg == mdmc_pkg::ST_LOOKUP)
        begin
            w_reg           <= '0;
            flush_addr_reg  <= is_core ? victim_addr : item_reg.address;
            shared_reg      <= !is_core && (item_reg.bus_command == mdmc_pkg::BUS_RD);
            reply_hit_reg   <= is_core ? core_hit : 1'b1;
            reply_stall_reg <= is_core && !core_hit;
            reply_load_reg  <= (is_core && core_hit && !item_reg.is_write) ? word_rdata : '0;
        end
        else if ((state_reg == mdmc_pkg::ST_PUT_WORD) && push)
        begin
            w_reg <= OFF_W'(w_reg + 1'b1);
        end
    end

`ifndef SYNTHESIS
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mdmc_pkg::ST_CLEAR) |-> (!out_valid_reg && !miss_pending_reg))
        else $error("Result or pending miss present during the clearing pass.");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_next.last) |=> (state_reg == mdmc_pkg::ST_IDLE))
        else $error("Sequencer did not return to idle after the final result.");

    a_pending_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(miss_pending_reg) |-> (($past(state_reg) == mdmc_pkg::ST_LOOKUP)
                                     && ($past(item_reg.action) == mdmc_pkg::ACT_CORE)))
        else $error("Miss pending set outside a core access lookup.");

    a_word_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mdmc_pkg::ST_PUT_WORD) |-> (($past(state_reg) == mdmc_pkg::ST_RD_WORD)
                                                 || ($past(state_reg) == mdmc_pkg::ST_PUT_WORD)))
        else $error("Flushed word sent without a preceding word read.");
`endif

endmodule

`default_nettype wire
